>>> rtl/quad_point_and_segment_hit_test_assert.svh
// Assertion macros for the quad hit test block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef QUAD_POINT_AND_SEGMENT_HIT_TEST_ASSERT_SVH
`define QUAD_POINT_AND_SEGMENT_HIT_TEST_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define QPSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QPSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qpsh_pkg.sv
// Shared widths, types and register indexes for the quad hit test block.
// No dependencies.
package qpsh_pkg;

  localparam int unsigned CoordWidth    = 16;
  localparam int unsigned DiffWidth     = CoordWidth + 1;
  localparam int unsigned ProdWidth     = 2 * DiffWidth;
  localparam int unsigned CrossWidth    = ProdWidth + 1;
  localparam int unsigned GapWidth      = CrossWidth + 1;
  localparam int unsigned NumCorners    = 4;
  localparam int unsigned CfgIdxWidth   = 4;
  localparam int unsigned InTdataWidth  = 4 * CoordWidth;
  localparam int unsigned OutTdataWidth = 8;

  typedef enum logic {
    OP_POINT   = 1'b0,
    OP_SEGMENT = 1'b1
  } opcode_e;

  localparam logic [CfgIdxWidth-1:0] REG_C1X = 4'd0;
  localparam logic [CfgIdxWidth-1:0] REG_C1Z = 4'd1;
  localparam logic [CfgIdxWidth-1:0] REG_C2X = 4'd2;
  localparam logic [CfgIdxWidth-1:0] REG_C2Z = 4'd3;
  localparam logic [CfgIdxWidth-1:0] REG_C3X = 4'd4;
  localparam logic [CfgIdxWidth-1:0] REG_C3Z = 4'd5;
  localparam logic [CfgIdxWidth-1:0] REG_C4X = 4'd6;
  localparam logic [CfgIdxWidth-1:0] REG_C4Z = 4'd7;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic signed [GapWidth-1:0]   gap_t;

  typedef struct packed {
    coord_t x;
    coord_t z;
  } corner_t;

  typedef struct packed {
    opcode_e opcode;
    coord_t  ax;
    coord_t  az;
    coord_t  bx;
    coord_t  bz;
  } query_t;

  // Six products per edge; side value of the point test equals rn.
  typedef struct packed {
    prod_t oz_ex;
    prod_t ox_ez;
    prod_t sx_ez;
    prod_t sz_ex;
    prod_t oz_sx;
    prod_t ox_sz;
  } edge_prod_t;

endpackage

>>> rtl/qpsh_cfg_regs.sv
// Corner register file for the quad hit test block.
// Depends on qpsh_pkg.
module qpsh_cfg_regs
  import qpsh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxWidth-1:0] wr_idx_i,
  input  coord_t                 wr_data_i,
  output corner_t                corners_o [NumCorners]
);

  corner_t corners_q [NumCorners];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCorners; i++) begin
        corners_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_C1X: corners_q[0].x <= wr_data_i;
        REG_C1Z: corners_q[0].z <= wr_data_i;
        REG_C2X: corners_q[1].x <= wr_data_i;
        REG_C2Z: corners_q[1].z <= wr_data_i;
        REG_C3X: corners_q[2].x <= wr_data_i;
        REG_C3Z: corners_q[2].z <= wr_data_i;
        REG_C4X: corners_q[3].x <= wr_data_i;
        REG_C4Z: corners_q[3].z <= wr_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  assign corners_o = corners_q;

endmodule

>>> rtl/qpsh_prod.sv
// Difference and product stage: six signed products for each quad edge.
// Depends on qpsh_pkg.
module qpsh_prod
  import qpsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  query_t     query_i,
  input  corner_t    corners_i [NumCorners],
  output opcode_e    opcode_o,
  output edge_prod_t prod_o [NumCorners]
);

  edge_prod_t prod_d [NumCorners];
  edge_prod_t prod_q [NumCorners];
  opcode_e    opcode_q;

  diff_t sx, sz;
  assign sx = DiffWidth'(query_i.bx) - DiffWidth'(query_i.ax);
  assign sz = DiffWidth'(query_i.bz) - DiffWidth'(query_i.az);

  for (genvar e = 0; e < NumCorners; e++) begin : g_edge
    localparam int unsigned Nxt = (e + 1) % NumCorners;
    diff_t ex, ez, ox, oz;

    assign ex = DiffWidth'(corners_i[Nxt].x) - DiffWidth'(corners_i[e].x);
    assign ez = DiffWidth'(corners_i[Nxt].z) - DiffWidth'(corners_i[e].z);
    assign ox = DiffWidth'(query_i.ax) - DiffWidth'(corners_i[e].x);
    assign oz = DiffWidth'(query_i.az) - DiffWidth'(corners_i[e].z);

    always_comb begin
      prod_d[e].oz_ex = ProdWidth'(oz) * ProdWidth'(ex);
      prod_d[e].ox_ez = ProdWidth'(ox) * ProdWidth'(ez);
      prod_d[e].sx_ez = ProdWidth'(sx) * ProdWidth'(ez);
      prod_d[e].sz_ex = ProdWidth'(sz) * ProdWidth'(ex);
      prod_d[e].oz_sx = ProdWidth'(oz) * ProdWidth'(sx);
      prod_d[e].ox_sz = ProdWidth'(ox) * ProdWidth'(sz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      opcode_q <= query_i.opcode;
    end
  end

  assign prod_o   = prod_q;
  assign opcode_o = opcode_q;

endmodule

>>> rtl/qpsh_decide.sv
// Decision stage: cross terms, sign and range compares, hit register.
// Depends on qpsh_pkg.
module qpsh_decide
  import qpsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  opcode_e    opcode_i,
  input  edge_prod_t prod_i [NumCorners],
  output logic       hit_o
);

  // num/den lies in [0,1]; den is nonzero when the result is used.
  function automatic logic in_unit(cross_t num, cross_t den);
    gap_t gap;
    gap = GapWidth'(den) - GapWidth'(num);
    if (!den[CrossWidth-1]) begin
      in_unit = !num[CrossWidth-1] && !gap[GapWidth-1];
    end else begin
      in_unit = (num[CrossWidth-1] || (num == '0)) && (gap[GapWidth-1] || (gap == '0));
    end
  endfunction

  logic [NumCorners-1:0] side_pos;
  logic [NumCorners-1:0] seg_hit;
  logic                  hit_d;
  logic                  hit_q;

  for (genvar e = 0; e < NumCorners; e++) begin : g_edge
    cross_t den, rn, sn;
    assign den = CrossWidth'(prod_i[e].sx_ez) - CrossWidth'(prod_i[e].sz_ex);
    assign rn  = CrossWidth'(prod_i[e].oz_ex) - CrossWidth'(prod_i[e].ox_ez);
    assign sn  = CrossWidth'(prod_i[e].oz_sx) - CrossWidth'(prod_i[e].ox_sz);

    assign side_pos[e] = !rn[CrossWidth-1] && (rn != '0);
    assign seg_hit[e]  = (den != '0) && in_unit(rn, den) && in_unit(sn, den);
  end

  always_comb begin
    case (opcode_i)
      OP_POINT:   hit_d = (side_pos == '0) || (side_pos == '1);
      OP_SEGMENT: hit_d = |seg_hit;
      default:    hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

>>> rtl/quad_point_and_segment_hit_test.sv
// Top level of the quad footprint hit test block.
// Depends on qpsh_pkg, qpsh_cfg_regs, qpsh_prod, qpsh_decide and the assert header.
//
// Usage:
//   Write the four corners of a quad in the x-z plane through the cfg channel
//   (index 0..7 = c1.x, c1.z, c2.x, c2.z, c3.x, c3.z, c4.x, c4.z); other
//   indexes are dropped. Edges run c1->c2->c3->c4->c1. Write only while idle.
//   Each transfer on the s_axis side is one query: tuser is the opcode
//   (point inside quad, or segment crossing any edge); tdata holds the
//   coordinates. Each query gives one transfer on the m_axis side whose
//   tdata bit 0 is the hit flag.
// Timing:
//   Three register stages: input register, product register (24 parallel
//   17x17 multipliers, six per edge) and result register, passed in that order
//   to m_axis_tvalid; one query per cycle while m_axis_tready does not stall.
//   Each stage holds its item only while the stage after it is full and
//   stalled, so bubbles are squeezed out and input is taken while a result
//   waits, until all three stages are full.
// Reset:
//   All corners read zero (a degenerate quad: every point test hits) and
//   the pipeline comes up empty.
`include "quad_point_and_segment_hit_test_assert.svh"

module quad_point_and_segment_hit_test
  import qpsh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [CoordWidth-1:0]    cfg_data_i,
  // Query stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: start_x [15:0], start_z [31:16], end_x [47:32], end_z [63:48]
  input  logic [InTdataWidth-1:0]  s_axis_tdata,
  // tuser: opcode [0]
  input  logic                     s_axis_tuser,
  // Result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: hit [0], zero fill [7:1]
  output logic [OutTdataWidth-1:0] m_axis_tdata
);

  corner_t    corners [NumCorners];
  query_t     query_q;
  opcode_e    prod_opcode;
  edge_prod_t prod [NumCorners];
  logic       hit;

  logic in_v_q, prod_v_q, out_v_q;
  logic in_v_d, prod_v_d, out_v_d;
  logic rdy_in, rdy_prod, rdy_out;

  // Config port is always ready; writes are registered in the corner register file.
  assign cfg_ready_o = 1'b1;

  qpsh_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (coord_t'(cfg_data_i)),
    .corners_o (corners)
  );

  // A stage may take a new item when empty or when its item moves on.
  assign rdy_out  = !out_v_q  || m_axis_tready;
  assign rdy_prod = !prod_v_q || rdy_out;
  assign rdy_in   = !in_v_q   || rdy_prod;
  assign s_axis_tready = rdy_in;

  assign in_v_d   = rdy_in   ? s_axis_tvalid : in_v_q;
  assign prod_v_d = rdy_prod ? in_v_q        : prod_v_q;
  assign out_v_d  = rdy_out  ? prod_v_q      : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      in_v_q   <= in_v_d;
      prod_v_q <= prod_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Input register: capture query fields on each input transfer.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy_in) begin
      query_q.opcode <= opcode_e'(s_axis_tuser);
      query_q.ax     <= s_axis_tdata[CoordWidth-1:0];
      query_q.az     <= s_axis_tdata[2*CoordWidth-1:CoordWidth];
      query_q.bx     <= s_axis_tdata[3*CoordWidth-1:2*CoordWidth];
      query_q.bz     <= s_axis_tdata[4*CoordWidth-1:3*CoordWidth];
    end
  end

  qpsh_prod u_prod (
    .clk_i     (clk_i),
    .en_i      (rdy_prod),
    .query_i   (query_q),
    .corners_i (corners),
    .opcode_o  (prod_opcode),
    .prod_o    (prod)
  );

  qpsh_decide u_decide (
    .clk_i    (clk_i),
    .en_i     (rdy_out),
    .opcode_i (prod_opcode),
    .prod_i   (prod),
    .hit_o    (hit)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutTdataWidth-1){1'b0}}, hit};

  // An accepted query always lands in the input stage.
  `QPSH_ASSERT_NEXT(a_in_capture, s_axis_tvalid && s_axis_tready, in_v_q,
                    "accepted query lost at input stage")
  // An item leaving the input stage always lands in the product stage.
  `QPSH_ASSERT_NEXT(a_prod_capture, in_v_q && rdy_prod, prod_v_q,
                    "query lost between input and product stage")
  // Input never stalls while the result stage is empty.
  `QPSH_ASSERT_NOW(a_no_false_stall, !out_v_q, s_axis_tready,
                   "input stalled with empty result stage")

endmodule
